@@ design/drf_pkg.sv @@
// ----------------------------------------------------------------------------
// drf_pkg
// Shared types and constants of the delimited record framer.
// ----------------------------------------------------------------------------
package drf_pkg;

    localparam int MAX_DELIM_DEF = 7;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    typedef enum logic [2:0] {
        CFG_START_LEN    = 3'd0,
        CFG_START_BYTES  = 3'd1,
        CFG_END_LEN      = 3'd2,
        CFG_END_BYTES    = 3'd3,
        CFG_IGNORE_LEN   = 3'd4,
        CFG_IGNORE_BYTES = 3'd5,
        CFG_REC_LIMIT    = 3'd6,
        CFG_REC_CAPACITY = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  start_len;
        logic [55:0] start_bytes;
        logic [2:0]  end_len;
        logic [55:0] end_bytes;
        logic [2:0]  ignore_len;
        logic [55:0] ignore_bytes;
        logic [15:0] record_limit;
        logic [15:0] record_capacity;
    } t_cfg;

    // classification of the lookahead window front
    typedef struct packed {
        logic       ign;
        logic       start_head;
        logic       start_full;
        logic       end_head;
        logic       end_full;
        logic [2:0] slen;
        logic [2:0] elen;
    } t_match;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        record_done;
        logic [15:0] record_count;
        logic        last;
    } t_result;

endpackage

@@ design/drf_if.sv @@
// ----------------------------------------------------------------------------
// drf_if
// Valid/ready channels of the framer: received bytes and record results.
// ----------------------------------------------------------------------------
interface drf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface drf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        record_done;
    logic [15:0] record_count;
    logic        last;

    modport source (output valid, output data_byte, output data_valid,
                    output record_done, output record_count, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input data_valid,
                    input record_done, input record_count, input last,
                    output ready);
endinterface

@@ design/drf_front.sv @@
// ----------------------------------------------------------------------------
// drf_front
// Receive side: takes raw bytes and holds them in a short queue for the
// decision sequencer.
// ----------------------------------------------------------------------------
module drf_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drf_in_if.sink      i_rx,
    drf_in_if.source    o_q
);

    localparam int QD = drf_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    logic [7:0]    r_buf [QD];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign i_rx.ready = (r_cnt != CW'(QD));
    assign o_q.valid  = (r_cnt != '0);
    assign o_q.rx_byte = r_buf[r_rd];

    assign w_push = i_rx.valid && i_rx.ready;
    assign w_pop  = o_q.valid && o_q.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(QD - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(QD - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_rx.rx_byte;
        end
    end

endmodule

@@ design/drf_match.sv @@
// ----------------------------------------------------------------------------
// drf_match
// Classifies the lookahead window against the start string, end string and
// ignore set.
// ----------------------------------------------------------------------------
module drf_match #(
    parameter int MAX_DELIM = drf_pkg::MAX_DELIM_DEF
) (
    input  logic [MAX_DELIM-1:0][7:0] i_win,
    input  drf_pkg::t_cfg             i_cfg,
    output drf_pkg::t_match           o_match
);

    localparam logic [2:0] MAXL = 3'(MAX_DELIM);

    logic [2:0] w_slen, w_elen, w_ilen;

    assign w_slen = (i_cfg.start_len  > MAXL) ? MAXL : i_cfg.start_len;
    assign w_elen = (i_cfg.end_len    > MAXL) ? MAXL : i_cfg.end_len;
    assign w_ilen = (i_cfg.ignore_len > MAXL) ? MAXL : i_cfg.ignore_len;

    always_comb begin
        o_match            = '0;
        o_match.slen       = w_slen;
        o_match.elen       = w_elen;
        o_match.start_head = (i_win[0] == i_cfg.start_bytes[7:0]);
        o_match.end_head   = (i_win[0] == i_cfg.end_bytes[7:0]);
        o_match.start_full = 1'b1;
        o_match.end_full   = 1'b1;
        for (int i = 0; i < MAX_DELIM; i++) begin
            if (3'(i) < w_ilen && i_win[0] == i_cfg.ignore_bytes[8*i +: 8]) begin
                o_match.ign = 1'b1;
            end
            if (3'(i) < w_slen && i_win[i] != i_cfg.start_bytes[8*i +: 8]) begin
                o_match.start_full = 1'b0;
            end
            if (3'(i) < w_elen && i_win[i] != i_cfg.end_bytes[8*i +: 8]) begin
                o_match.end_full = 1'b0;
            end
        end
    end

endmodule

@@ design/drf_back.sv @@
// ----------------------------------------------------------------------------
// drf_back
// Decision sequencer: keeps the lookahead window, phase and count, decides one
// window step per cycle unless stalled and hands results to the output stage.
// ----------------------------------------------------------------------------
module drf_back #(
    parameter int MAX_DELIM = drf_pkg::MAX_DELIM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  drf_pkg::t_cfg i_cfg,
    drf_in_if.sink        i_q,
    drf_out_if.source     o_res
);

    localparam int FW = $clog2(MAX_DELIM + 1);

    logic [MAX_DELIM-1:0][7:0] r_win, n_win;
    logic [FW-1:0]             r_fill, n_fill;
    logic                      r_collect, n_collect;
    logic [15:0]               r_count, n_count;
    logic                      r_busy, n_busy;
    drf_pkg::t_result          r_pend, n_pend, r_out, n_out;
    logic                      r_pend_valid, n_pend_valid;
    logic                      r_out_valid, n_out_valid;

    drf_pkg::t_match w_m;

    // decision of the current window step
    logic          d_brk, d_emit, d_collect, d_stored;
    logic [FW-1:0] d_drop;
    logic [15:0]   d_count, d_eff, d_cnt1;
    drf_pkg::t_result d_res;

    logic w_fill_z, w_end_head, w_out_take, w_out_free, w_step, w_load;
    logic [2:0] w_fill3;

    drf_match #(.MAX_DELIM(MAX_DELIM)) u_match (
        .i_win   (r_win),
        .i_cfg   (i_cfg),
        .o_match (w_m)
    );

    assign w_fill_z   = (r_fill == '0);
    assign w_fill3    = 3'(r_fill);
    assign w_end_head = (w_m.elen != 3'd0) && w_m.end_head;

    always_comb begin
        d_brk     = 1'b0;
        d_emit    = 1'b0;
        d_drop    = '0;
        d_collect = r_collect;
        d_count   = r_count;
        d_stored  = 1'b0;
        d_res     = '0;
        d_eff     = (i_cfg.record_limit != 16'd0) ? i_cfg.record_limit :
                    (w_m.elen == 3'd0) ? i_cfg.record_capacity : 16'd0;
        d_cnt1    = r_count;
        if (!r_collect) begin
            if (w_m.slen == 3'd0) begin
                d_collect = 1'b1;
            end else if (w_fill_z) begin
                d_brk = 1'b1;
            end else if (!w_m.start_head) begin
                d_drop = FW'(1);
            end else if (w_fill3 < w_m.slen) begin
                d_brk = 1'b1;
            end else if (w_m.start_full) begin
                d_drop    = FW'(w_m.slen);
                d_collect = 1'b1;
            end else begin
                d_drop = FW'(1);
            end
        end else begin
            if (w_fill_z) begin
                d_brk = 1'b1;
            end else if (w_m.ign) begin
                d_drop = FW'(1);
            end else if (w_end_head && w_fill3 < w_m.elen) begin
                // partial end string, wait for more bytes
                d_brk = 1'b1;
            end else if (w_end_head && w_m.end_full) begin
                d_drop            = FW'(w_m.elen);
                d_emit            = 1'b1;
                d_res.record_done = 1'b1;
                d_res.record_count = r_count;
                d_count           = '0;
                d_collect         = 1'b0;
            end else begin
                d_drop   = FW'(1);
                d_stored = (r_count < i_cfg.record_capacity) || (d_eff != 16'd0);
                d_cnt1   = d_stored ? r_count + 16'd1 : r_count;
                d_res.data_byte    = d_stored ? r_win[0] : 8'd0;
                d_res.data_valid   = d_stored;
                d_res.record_count = d_cnt1;
                if (d_cnt1 == d_eff) begin
                    d_emit            = 1'b1;
                    d_res.record_done = 1'b1;
                    d_count           = '0;
                    d_collect         = 1'b0;
                end else begin
                    d_emit  = d_stored;
                    d_count = d_cnt1;
                end
            end
        end
    end

    assign w_out_take = r_out_valid && o_res.ready;
    assign w_out_free = !r_out_valid || w_out_take;
    assign w_step     = r_busy && !d_brk && (!d_emit || !r_pend_valid || w_out_free);

    // a new byte enters when the previous one has no decision left
    assign i_q.ready = !r_busy || d_brk;
    assign w_load    = i_q.valid && i_q.ready;

    always_comb begin
        n_win     = r_win;
        n_fill    = r_fill;
        n_collect = r_collect;
        n_count   = r_count;
        n_busy    = r_busy;
        if (w_step) begin
            for (int i = 0; i < MAX_DELIM; i++) begin
                if (d_drop != '0) begin
                    n_win[i] = '0;
                end
                for (int k = 1; k <= MAX_DELIM; k++) begin
                    if (d_drop == FW'(k) && i + k < MAX_DELIM) begin
                        n_win[i] = r_win[i + k];
                    end
                end
            end
            n_fill    = r_fill - d_drop;
            n_collect = d_collect;
            n_count   = d_count;
        end else if (r_busy && d_brk) begin
            n_busy = 1'b0;
        end
        if (w_load) begin
            n_busy = 1'b1;
            if (r_fill == FW'(MAX_DELIM)) begin
                // full window: oldest byte falls out
                for (int i = 0; i < MAX_DELIM - 1; i++) begin
                    n_win[i] = r_win[i + 1];
                end
                n_win[MAX_DELIM-1] = i_q.rx_byte;
            end else begin
                for (int i = 0; i < MAX_DELIM; i++) begin
                    if (FW'(i) == r_fill) begin
                        n_win[i] = i_q.rx_byte;
                    end
                end
                n_fill = r_fill + FW'(1);
            end
        end
    end

    // pending result waits until the next result or the end of the item
    // tells whether it is the last one
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid && !w_out_take;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        if (w_step && d_emit) begin
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out_valid = 1'b1;
            end
            n_pend       = d_res;
            n_pend.last  = 1'b0;
            n_pend_valid = 1'b1;
        end else if (r_pend_valid && r_pend.last && w_out_free) begin
            n_out        = r_pend;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end else if (r_busy && d_brk && r_pend_valid) begin
            n_pend.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_collect    <= 1'b0;
            r_count      <= '0;
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_win        <= '0;
        end else begin
            r_fill       <= n_fill;
            r_collect    <= n_collect;
            r_count      <= n_count;
            r_busy       <= n_busy;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_win        <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.data_byte    = r_out.data_byte;
    assign o_res.data_valid   = r_out.data_valid;
    assign o_res.record_done  = r_out.record_done;
    assign o_res.record_count = r_out.record_count;
    assign o_res.last         = r_out.last;

endmodule

@@ design/delimited_record_framer_top.sv @@
// ----------------------------------------------------------------------------
// delimited_record_framer_top
// Cuts a received byte stream into records framed by start and end strings.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_rx      in   valid/ready        rx_byte
//  o_res     out  valid/ready        data_byte, data_valid, record_done,
//                                    record_count, last
//  i_cfg_*   in   write enable only  i_cfg_idx, i_cfg_data
//
//  an item first enters the lookahead window, then the window is decided
//  in steps until a decision needs more bytes; the decision sequencer takes
//  one window step per cycle unless a result is held by a stalled output
//  results leave through a pending register and an output register
//  reset is synchronous: window empty, hunting, count zero, defaults loaded
//  a stalled output holds its result while the queue fills up with new items
// ----------------------------------------------------------------------------
module delimited_record_framer_top #(
    parameter int MAX_DELIM = drf_pkg::MAX_DELIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drf_in_if.sink      i_rx,
    drf_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [55:0] i_cfg_data
);

    drf_pkg::t_cfg r_cfg;

    drf_in_if q_ch ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                start_len:       3'd0,
                start_bytes:     56'd0,
                end_len:         3'd1,
                end_bytes:       56'(drf_pkg::CR_BYTE),
                ignore_len:      3'd1,
                ignore_bytes:    56'(drf_pkg::LF_BYTE),
                record_limit:    16'd0,
                record_capacity: 16'd256
            };
        end else if (i_cfg_we) begin
            unique case (drf_pkg::t_cfg_idx'(i_cfg_idx))
                drf_pkg::CFG_START_LEN:    r_cfg.start_len       <= i_cfg_data[2:0];
                drf_pkg::CFG_START_BYTES:  r_cfg.start_bytes     <= i_cfg_data;
                drf_pkg::CFG_END_LEN:      r_cfg.end_len         <= i_cfg_data[2:0];
                drf_pkg::CFG_END_BYTES:    r_cfg.end_bytes       <= i_cfg_data;
                drf_pkg::CFG_IGNORE_LEN:   r_cfg.ignore_len      <= i_cfg_data[2:0];
                drf_pkg::CFG_IGNORE_BYTES: r_cfg.ignore_bytes    <= i_cfg_data;
                drf_pkg::CFG_REC_LIMIT:    r_cfg.record_limit    <= i_cfg_data[15:0];
                drf_pkg::CFG_REC_CAPACITY: r_cfg.record_capacity <= i_cfg_data[15:0];
            endcase
        end
    end

    drf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .o_q     (q_ch.source)
    );

    drf_back #(.MAX_DELIM(MAX_DELIM)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q     (q_ch.sink),
        .o_res   (o_res)
    );

endmodule

@@ design/drf_checker.sv @@
// ----------------------------------------------------------------------------
// drf_checker
// Port-level checks of the framer, bound to the top level.
// ----------------------------------------------------------------------------
module drf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_data_valid,
    input logic        i_record_done,
    input logic [15:0] i_record_count,
    input logic        i_last
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
            && $stable(i_record_count) && $stable(i_record_done) && $stable(i_last))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // a result without a stored byte only ever closes a record
    a_no_data_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_record_done && i_data_byte == 8'd0)
        else $error("empty result that does not end a record");

endmodule

bind delimited_record_framer_top drf_checker u_drf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_data_byte    (o_res.data_byte),
    .i_data_valid   (o_res.data_valid),
    .i_record_done  (o_res.record_done),
    .i_record_count (o_res.record_count),
    .i_last         (o_res.last)
);

@@ tb/tb_delimited_record_framer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delimited_record_framer_top
// Sends received bytes into the framer and checks every record result
// against a byte-level framing predictor kept inside the bench. A short
// directed part runs first, then randomized framing settings, each fed
// with start/payload/end sequences mixed with noise and broken strings.
// ----------------------------------------------------------------------------
module tb_delimited_record_framer_top;
    import drf_pkg::*;

    localparam int          WIN_DEPTH     = MAX_DELIM_DEF;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned ITEMS_PER_SET = 18;
    localparam int unsigned RANDOM_SETS   = 6;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [55:0] cfg_data;

    drf_in_if  rx_ch ();
    drf_out_if res_ch ();

    delimited_record_framer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // framing predictor state
    t_cfg        model_cfg;
    logic [7:0]  win_q [WIN_DEPTH];
    int unsigned win_fill = 0;
    bit          collecting = 1'b0;
    logic [15:0] rec_count = '0;

    logic [7:0]  bytes_to_send [$];
    t_result     results_due [$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned queued = 0;
    int unsigned rx_gap = 0;
    int unsigned res_stall = 0;
    bit          steady = 1'b0;
    bit          rx_fire = 1'b0;

    function automatic void drop_front(int unsigned n);
        if (n >= win_fill) begin
            win_fill = 0;
        end else begin
            for (int unsigned i = 0; i < win_fill - n; i++) win_q[i] = win_q[i + n];
            win_fill = win_fill - n;
        end
    endfunction

    function automatic bit front_matches(logic [55:0] pattern, int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (win_q[i] != pattern[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit is_ignored(logic [7:0] b);
        for (int unsigned i = 0; i < model_cfg.ignore_len; i++) begin
            if (b == model_cfg.ignore_bytes[8*i +: 8]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result make_result(logic [7:0] d, bit v, bit done);
        t_result r;
        r.data_byte    = v ? d : 8'h00;
        r.data_valid   = v;
        r.record_done  = done;
        r.record_count = rec_count;
        r.last         = 1'b0;
        return r;
    endfunction

    // decide as many window bytes as possible after one byte arrives
    function automatic void frame_byte(logic [7:0] rx);
        t_result     batch [$];
        logic [7:0]  head;
        logic [15:0] eff_limit;
        int unsigned slen;
        int unsigned elen;
        bit          more;
        bit          kept;
        if (win_fill >= WIN_DEPTH) drop_front(1);
        win_q[win_fill] = rx;
        win_fill++;
        more = 1'b1;
        while (more) begin
            slen = model_cfg.start_len;
            elen = model_cfg.end_len;
            if (!collecting) begin
                if (slen == 0) begin
                    collecting = 1'b1;
                end else if (win_fill == 0) begin
                    more = 1'b0;
                end else if (win_q[0] != model_cfg.start_bytes[7:0]) begin
                    drop_front(1);
                end else if (win_fill < slen) begin
                    more = 1'b0;
                end else if (front_matches(model_cfg.start_bytes, slen)) begin
                    drop_front(slen);
                    collecting = 1'b1;
                end else begin
                    drop_front(1);
                end
            end else if (win_fill == 0) begin
                more = 1'b0;
            end else begin
                head = win_q[0];
                if (model_cfg.record_limit != 0) begin
                    eff_limit = model_cfg.record_limit;
                end else if (elen == 0) begin
                    eff_limit = model_cfg.record_capacity;
                end else begin
                    eff_limit = '0;
                end
                if (is_ignored(head)) begin
                    drop_front(1);
                end else if (elen != 0 && head == model_cfg.end_bytes[7:0]
                             && win_fill < elen) begin
                    more = 1'b0;
                end else if (elen != 0 && head == model_cfg.end_bytes[7:0]
                             && front_matches(model_cfg.end_bytes, elen)) begin
                    drop_front(elen);
                    batch.push_back(make_result(8'h00, 1'b0, 1'b1));
                    collecting = 1'b0;
                    rec_count  = '0;
                end else begin
                    drop_front(1);
                    kept = (rec_count < model_cfg.record_capacity) || (eff_limit != 0);
                    if (kept) rec_count = rec_count + 16'd1;
                    if (rec_count == eff_limit) begin
                        batch.push_back(make_result(head, kept, 1'b1));
                        collecting = 1'b0;
                        rec_count  = '0;
                    end else if (kept) begin
                        batch.push_back(make_result(head, 1'b1, 1'b0));
                    end
                end
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) results_due.push_back(batch[i]);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void flag_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else if (!rx_ch.valid || rx_fire) begin
            if (rx_gap > 0) begin
                rx_gap = rx_gap - 1;
                rx_ch.valid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= bytes_to_send.pop_front();
                rx_gap = pick_gap();
            end else begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_stall == 0 && !steady && $urandom_range(0, 3) == 0) res_stall = pick_gap();
            if (res_stall > 0) begin
                res_stall = res_stall - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // accepted item goes through the predictor
    always @(posedge i_clk) begin
        rx_fire <= i_rst_n && rx_ch.valid && rx_ch.ready;
        if (i_rst_n && rx_ch.valid && rx_ch.ready) frame_byte(rx_ch.rx_byte);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual byte %0h valid %0b done %0b count %0h last %0b",
                         $time, res_ch.data_byte, res_ch.data_valid, res_ch.record_done,
                         res_ch.record_count, res_ch.last);
            end else begin
                want = results_due.pop_front();
                flag_field("data_byte", want.data_byte, res_ch.data_byte);
                flag_field("data_valid", want.data_valid, res_ch.data_valid);
                flag_field("record_done", want.record_done, res_ch.record_done);
                flag_field("record_count", want.record_count, res_ch.record_count);
                flag_field("last", want.last, res_ch.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        bytes_to_send.push_back(b);
        queued++;
    endtask

    // wait until every item is in and every result is out, then let the window settle
    task automatic settle();
        while (bytes_to_send.size() != 0 || rx_ch.valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [55:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_START_LEN:    model_cfg.start_len       = value[2:0];
            CFG_START_BYTES:  model_cfg.start_bytes     = value;
            CFG_END_LEN:      model_cfg.end_len         = value[2:0];
            CFG_END_BYTES:    model_cfg.end_bytes       = value;
            CFG_IGNORE_LEN:   model_cfg.ignore_len      = value[2:0];
            CFG_IGNORE_BYTES: model_cfg.ignore_bytes    = value;
            CFG_REC_LIMIT:    model_cfg.record_limit    = value[15:0];
            CFG_REC_CAPACITY: model_cfg.record_capacity = value[15:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // narrow patterns use only two letters so partial matches and overlaps are common
    function automatic logic [55:0] rand_pattern(bit narrow);
        logic [55:0] p;
        for (int i = 0; i < 7; i++)
            p[8*i +: 8] = narrow ? 8'(8'h41 + $urandom_range(0, 1)) : 8'($urandom_range(0, 255));
        return p;
    endfunction

    function automatic logic [7:0] payload_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return 8'($urandom_range(0, 255));
        if (r < 7) return 8'(8'h41 + $urandom_range(0, 1));
        if (r < 8 && model_cfg.ignore_len != 0)
            return model_cfg.ignore_bytes[8*$urandom_range(0, model_cfg.ignore_len - 1) +: 8];
        if (r < 9 && model_cfg.start_len != 0)
            return model_cfg.start_bytes[8*$urandom_range(0, model_cfg.start_len - 1) +: 8];
        if (model_cfg.end_len != 0)
            return model_cfg.end_bytes[8*$urandom_range(0, model_cfg.end_len - 1) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    // one start/payload/end sequence, sometimes noise or a broken delimiter
    task automatic queue_record();
        int unsigned kind;
        int unsigned n;
        int unsigned bad;
        int unsigned cut;
        logic [7:0]  b;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else begin
            bad = (kind == 1 && model_cfg.start_len != 0) ?
                  $urandom_range(0, model_cfg.start_len - 1) : WIN_DEPTH;
            for (int unsigned i = 0; i < model_cfg.start_len; i++) begin
                b = model_cfg.start_bytes[8*i +: 8];
                if (i == bad) b = b ^ (8'h01 << $urandom_range(0, 7));
                send_byte(b);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
            repeat (n) send_byte(payload_byte());
            cut = model_cfg.end_len;
            if (kind == 2 && cut != 0) cut = $urandom_range(0, cut - 1);
            for (int unsigned i = 0; i < cut; i++) send_byte(model_cfg.end_bytes[8*i +: 8]);
        end
    endtask

    task automatic pick_settings(int unsigned set_no);
        logic [2:0]  slen, elen, ilen;
        logic [15:0] limit, capacity;
        bit          narrow;
        narrow = $urandom_range(0, 1);
        slen   = 3'($urandom_range(0, 7));
        elen   = 3'($urandom_range(0, 7));
        ilen   = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 5))
            3:       limit = 16'd1;
            4:       limit = 16'($urandom_range(2, 8));
            5:       limit = 16'hFFFF;
            default: limit = 16'd0;
        endcase
        case ($urandom_range(0, 3))
            0:       capacity = 16'd0;
            1:       capacity = 16'($urandom_range(1, 8));
            2:       capacity = 16'd256;
            default: capacity = 16'hFFFF;
        endcase
        if (set_no == 0) begin
            // every length and count at its top
            narrow = 1'b1;
            slen = 3'd7; elen = 3'd7; ilen = 3'd7;
            limit = 16'hFFFF; capacity = 16'hFFFF;
        end else if (set_no == 1) begin
            slen = '0; elen = '0; ilen = '0;
            limit = '0; capacity = '0;
        end
        write_reg(CFG_START_LEN, 56'(slen));
        write_reg(CFG_START_BYTES, set_no == 1 ? 56'h0 : rand_pattern(narrow));
        write_reg(CFG_END_LEN, 56'(elen));
        write_reg(CFG_END_BYTES, set_no == 1 ? 56'h0 : rand_pattern(narrow));
        write_reg(CFG_IGNORE_LEN, 56'(ilen));
        write_reg(CFG_IGNORE_BYTES, set_no == 1 ? 56'h0 : rand_pattern(1'b0));
        write_reg(CFG_REC_LIMIT, 56'(limit));
        write_reg(CFG_REC_CAPACITY, 56'(capacity));
        close_writes();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        res_ch.ready   = 1'b0;
        model_cfg      = '0;
        model_cfg.end_len         = 3'd1;
        model_cfg.end_bytes       = 56'(CR_BYTE);
        model_cfg.ignore_len      = 3'd1;
        model_cfg.ignore_bytes    = 56'(LF_BYTE);
        model_cfg.record_capacity = 16'd256;
        for (int i = 0; i < WIN_DEPTH; i++) win_q[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset: byte extremes, ignored line feed, carriage return ends
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(LF_BYTE);
        send_byte(8'h41);
        send_byte(CR_BYTE);
        settle();

        // two-byte start and end strings, empty ignore set, partial matches
        write_reg(CFG_START_LEN, 56'd2);
        write_reg(CFG_START_BYTES, 56'h7B53);
        write_reg(CFG_END_LEN, 56'd2);
        write_reg(CFG_END_BYTES, {40'h0, LF_BYTE, CR_BYTE});
        write_reg(CFG_IGNORE_LEN, 56'd0);
        write_reg(CFG_IGNORE_BYTES, 56'h0);
        write_reg(CFG_REC_LIMIT, 56'd0);
        write_reg(CFG_REC_CAPACITY, 56'd256);
        close_writes();
        send_byte(8'h78);
        send_byte(8'h53);
        send_byte(8'h53);
        send_byte(8'h7B);
        send_byte(8'h61);
        send_byte(CR_BYTE);
        send_byte(8'h62);
        send_byte(CR_BYTE);
        send_byte(LF_BYTE);
        settle();

        // no start hunt, no end string: capacity acts as the limit
        write_reg(CFG_START_LEN, 56'd0);
        write_reg(CFG_END_LEN, 56'd0);
        write_reg(CFG_REC_CAPACITY, 56'd2);
        close_writes();
        send_byte(8'h31);
        send_byte(8'h32);
        send_byte(8'h33);
        settle();

        // zero capacity without limit, switched in with a record open
        write_reg(CFG_END_LEN, 56'd1);
        write_reg(CFG_END_BYTES, 56'(CR_BYTE));
        write_reg(CFG_REC_CAPACITY, 56'd0);
        close_writes();
        send_byte(8'h34);
        send_byte(CR_BYTE);
        send_byte(8'h35);
        settle();

        // limit lowered below the count mid-record, then raised to be hit
        write_reg(CFG_REC_CAPACITY, 56'd256);
        close_writes();
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(8'h63);
        settle();
        write_reg(CFG_REC_LIMIT, 56'd2);
        close_writes();
        send_byte(8'h64);
        settle();
        write_reg(CFG_REC_LIMIT, 56'd5);
        close_writes();
        send_byte(8'h65);
        settle();

        for (int unsigned s = 0; s < RANDOM_SETS; s++) begin
            pick_settings(s);
            steady = (s == 3);
            queued = 0;
            while (queued < ITEMS_PER_SET) queue_record();
            settle();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/drf_pkg.sv
design/drf_if.sv
design/drf_front.sv
design/drf_match.sv
design/drf_back.sv
design/delimited_record_framer_top.sv
design/drf_checker.sv
tb/tb_delimited_record_framer_top.sv
